### rtl/bhcm_pkg.sv
// ----------------------------------------------------------------------------
// bhcm_pkg
// Types and codes shared by the bump heap chunk manager modules.
// ----------------------------------------------------------------------------
package bhcm_pkg;

  localparam int SIZE_W = 13;
  localparam int ID_W   = 16;
  localparam int ADDR_W = 12;
  localparam int ACT_W  = 3;
  localparam int IDX_W  = 2;
  localparam int HDR_W  = SIZE_W + ID_W;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FREE    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SHIFT   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_COMPACT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd4;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_HEAP_BYTES = 2'd0;
  localparam logic [IDX_W-1:0] REG_ALIGN_EVEN = 2'd1;
  localparam logic [IDX_W-1:0] REG_FREE_ID    = 2'd2;
  localparam logic [IDX_W-1:0] REG_INVALID_ID = 2'd3;

  typedef struct packed {
    logic [SIZE_W-1:0] heap_bytes;
    logic              align_even;
    logic [ID_W-1:0]   free_id;
    logic [ID_W-1:0]   invalid_id;
  } cfg_t;

  // chunk header: id in the upper bits, total chunk size in the lower bits
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   chunk_id;
    logic [ID_W-1:0]   id_range;
    logic [ADDR_W-1:0] address;
  } item_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] payload_offset;
    logic [SIZE_W-1:0] free_bytes;
    logic [SIZE_W-1:0] reclaimed_bytes;
  } result_t;

  // outcome of evaluating one header during a walk
  typedef struct packed {
    logic              walk_ok;
    logic              wr_en;
    logic [SIZE_W-1:0] wr_loc;
    hdr_t              wr_hdr;
    logic [SIZE_W-1:0] next_loc;
    logic [SIZE_W-1:0] shift_acc;
  } step_t;

endpackage

### rtl/bhcm_ram.sv
// ----------------------------------------------------------------------------
// bhcm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bhcm_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/bhcm_hdr_unit.sv
// ----------------------------------------------------------------------------
// bhcm_hdr_unit
// Shared header evaluation unit, used once per chunk of a shift or compact
// walk: checks the chain, rewrites ids or computes the compaction move.
// ----------------------------------------------------------------------------
module bhcm_hdr_unit (
  input  logic                        is_compact,
  input  bhcm_pkg::hdr_t              hdr,
  input  logic [bhcm_pkg::SIZE_W-1:0] loc,
  input  logic [bhcm_pkg::SIZE_W-1:0] top,
  input  logic [bhcm_pkg::SIZE_W-1:0] shift,
  input  logic [bhcm_pkg::ID_W-1:0]   start_id,
  input  logic [bhcm_pkg::ID_W-1:0]   id_range,
  input  logic [bhcm_pkg::ID_W-1:0]   free_id,
  input  logic [bhcm_pkg::ID_W-1:0]   invalid_id,
  output bhcm_pkg::step_t             step
);

  logic [bhcm_pkg::SIZE_W:0] chunk_end;
  logic [bhcm_pkg::ID_W:0]   limit;
  logic [bhcm_pkg::ID_W:0]   id_ext;
  logic [bhcm_pkg::ID_W-1:0] new_id;
  logic                      walk_ok;

  assign chunk_end = {1'b0, loc} + {1'b0, hdr.size};
  assign walk_ok   = (hdr.size != '0) && (chunk_end <= {1'b0, top});
  assign limit     = {1'b0, start_id} + {1'b0, id_range};
  assign id_ext    = {1'b0, hdr.id};

  // removed ids become invalid, ids above the removed range close the gap
  always_comb begin
    if (hdr.id >= start_id && id_ext < limit) begin
      new_id = invalid_id;
    end else if (id_ext >= limit) begin
      new_id = hdr.id - id_range;
    end else begin
      new_id = hdr.id;
    end
  end

  always_comb begin
    step          = '0;
    step.walk_ok  = walk_ok;
    step.next_loc = chunk_end[bhcm_pkg::SIZE_W-1:0];
    step.shift_acc = shift;
    if (is_compact) begin
      if (hdr.id == free_id) begin
        step.shift_acc = shift + hdr.size;
      end else begin
        step.wr_en  = walk_ok && (shift != '0);
        step.wr_loc = loc - shift;
        step.wr_hdr = hdr;
      end
    end else begin
      step.wr_en       = walk_ok;
      step.wr_loc      = loc;
      step.wr_hdr.id   = new_id;
      step.wr_hdr.size = hdr.size;
    end
  end

endmodule

### rtl/bhcm_seq.sv
// ----------------------------------------------------------------------------
// bhcm_seq
// Sequencer of the chunk manager: holds the top of heap, runs alloc and free,
// and steps the header walk of shift and compact through the shared unit.
// ----------------------------------------------------------------------------
module bhcm_seq #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bhcm_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bhcm_pkg::item_t               in_item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bhcm_pkg::result_t             res,
  output logic                          ram_we,
  output logic [$clog2(HEAP_BYTES)-1:0] ram_waddr,
  output logic [bhcm_pkg::HDR_W-1:0]    ram_wdata,
  output logic                          ram_re,
  output logic [$clog2(HEAP_BYTES)-1:0] ram_raddr,
  input  logic [bhcm_pkg::HDR_W-1:0]    ram_rdata
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int SW = bhcm_pkg::SIZE_W;
  localparam int IW = bhcm_pkg::ID_W;
  localparam int PW = bhcm_pkg::ADDR_W;

  localparam logic [16:0]   HEAP_EXT = 17'(HEAP_BYTES);
  localparam logic [SW:0]   HB_EXT   = (SW + 1)'(HEADER_BYTES);
  localparam logic [PW-1:0] HB_ADDR  = PW'(HEADER_BYTES);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ALLOC   = 3'd1;
  localparam logic [2:0] S_FREE    = 3'd2;
  localparam logic [2:0] S_WALK_RD = 3'd3;
  localparam logic [2:0] S_WALK_EV = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] top_r, top_nxt;
  logic [SW-1:0] loc_r, loc_nxt;
  logic [SW-1:0] shift_r, shift_nxt;
  logic          compact_r, compact_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [IW-1:0] cid_r, cid_nxt;
  logic [IW-1:0] range_r, range_nxt;
  logic [PW-1:0] hloc_r, hloc_nxt;
  logic          status_r, status_nxt;
  logic [PW-1:0] payload_r, payload_nxt;
  logic [SW-1:0] reclaimed_r, reclaimed_nxt;

  logic [16:0]   end_ext;
  logic [SW-1:0] end_off;
  logic [SW-1:0] space_left;
  logic [PW-1:0] in_hloc;
  logic          in_free_ok;
  logic [SW:0]   total;
  logic [SW:0]   free_end;
  logic [SW-1:0] wloc;
  logic [SW-1:0] rloc;
  logic [16:0]   waddr_ext;
  logic [16:0]   raddr_ext;

  bhcm_pkg::hdr_t  rd_hdr;
  bhcm_pkg::hdr_t  wr_hdr;
  bhcm_pkg::step_t step;

  assign rd_hdr = bhcm_pkg::hdr_t'(ram_rdata);

  // end of allocatable space is the register clipped to the store size
  assign end_ext    = ({4'b0, cfg.heap_bytes} > HEAP_EXT) ? HEAP_EXT : {4'b0, cfg.heap_bytes};
  assign end_off    = end_ext[SW-1:0];
  assign space_left = (top_r >= end_off) ? '0 : end_off - top_r;

  assign in_hloc    = in_item.address - HB_ADDR;
  assign in_free_ok = (in_item.address >= HB_ADDR) && ({5'b0, in_hloc} < HEAP_EXT);

  assign total    = {1'b0, size_r} + (SW + 1)'(cfg.align_even & size_r[0]) + HB_EXT;
  assign free_end = {2'b0, hloc_r} + {1'b0, rd_hdr.size};

  bhcm_hdr_unit u_hdr (
    .is_compact (compact_r),
    .hdr        (rd_hdr),
    .loc        (loc_r),
    .top        (top_r),
    .shift      (shift_r),
    .start_id   (cid_r),
    .id_range   (range_r),
    .free_id    (cfg.free_id),
    .invalid_id (cfg.invalid_id),
    .step       (step)
  );

  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    loc_nxt       = loc_r;
    shift_nxt     = shift_r;
    compact_nxt   = compact_r;
    size_nxt      = size_r;
    cid_nxt       = cid_r;
    range_nxt     = range_r;
    hloc_nxt      = hloc_r;
    status_nxt    = status_r;
    payload_nxt   = payload_r;
    reclaimed_nxt = reclaimed_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    wloc          = top_r;
    rloc          = loc_r;
    wr_hdr        = step.wr_hdr;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          size_nxt      = in_item.size;
          cid_nxt       = in_item.chunk_id;
          range_nxt     = in_item.id_range;
          hloc_nxt      = in_hloc;
          status_nxt    = 1'b0;
          payload_nxt   = '0;
          reclaimed_nxt = '0;
          loc_nxt       = '0;
          shift_nxt     = '0;
          compact_nxt   = (in_item.action == bhcm_pkg::ACT_COMPACT);
          case (in_item.action)
            bhcm_pkg::ACT_ALLOC: begin
              state_nxt = S_ALLOC;
            end
            bhcm_pkg::ACT_FREE: begin
              if (in_free_ok) begin
                ram_re    = 1'b1;
                rloc      = {1'b0, in_hloc};
                state_nxt = S_FREE;
              end else begin
                state_nxt = S_DONE;
              end
            end
            bhcm_pkg::ACT_SHIFT, bhcm_pkg::ACT_COMPACT: begin
              state_nxt = S_WALK_RD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_ALLOC: begin
        if ({1'b0, space_left} < total) begin
          status_nxt = 1'b1;
        end else begin
          ram_we      = 1'b1;
          wloc        = top_r;
          wr_hdr.id   = cid_r;
          wr_hdr.size = total[SW-1:0];
          payload_nxt = PW'(top_r + HB_EXT[SW-1:0]);
          top_nxt     = top_r + total[SW-1:0];
        end
        state_nxt = S_DONE;
      end

      S_FREE: begin
        // the top chunk just gives its space back, others get marked free
        if (free_end == {1'b0, top_r}) begin
          top_nxt = {1'b0, hloc_r};
        end else begin
          ram_we      = 1'b1;
          wloc        = {1'b0, hloc_r};
          wr_hdr.id   = cfg.free_id;
          wr_hdr.size = rd_hdr.size;
        end
        state_nxt = S_DONE;
      end

      S_WALK_RD: begin
        if (loc_r < top_r) begin
          ram_re    = 1'b1;
          rloc      = loc_r;
          state_nxt = S_WALK_EV;
        end else begin
          top_nxt       = top_r - shift_r;
          reclaimed_nxt = shift_r;
          state_nxt     = S_DONE;
        end
      end

      S_WALK_EV: begin
        if (step.walk_ok) begin
          ram_we    = step.wr_en;
          wloc      = step.wr_loc;
          loc_nxt   = step.next_loc;
          shift_nxt = step.shift_acc;
          state_nxt = S_WALK_RD;
        end else begin
          // broken chain ends the walk here
          top_nxt       = top_r - shift_r;
          reclaimed_nxt = shift_r;
          state_nxt     = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign waddr_ext = {4'b0, wloc};
  assign raddr_ext = {4'b0, rloc};
  assign ram_waddr = waddr_ext[AW-1:0];
  assign ram_raddr = raddr_ext[AW-1:0];
  assign ram_wdata = wr_hdr;

  assign res.status          = status_r;
  assign res.payload_offset  = payload_r;
  assign res.free_bytes      = space_left;
  assign res.reclaimed_bytes = reclaimed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      top_r   <= '0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    loc_r       <= loc_nxt;
    shift_r     <= shift_nxt;
    compact_r   <= compact_nxt;
    size_r      <= size_nxt;
    cid_r       <= cid_nxt;
    range_r     <= range_nxt;
    hloc_r      <= hloc_nxt;
    status_r    <= status_nxt;
    payload_r   <= payload_nxt;
    reclaimed_r <= reclaimed_nxt;
  end

endmodule

### rtl/bump_heap_chunk_manager_core.sv
// ----------------------------------------------------------------------------
// bump_heap_chunk_manager_core
// Bump-pointer heap of chunk headers with alloc, free, id shift and compact.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   request beats: tuser carries the action, tdata the operands.
//   out_*  one result beat per request: status, payload offset, free bytes
//          and reclaimed bytes.
//   cfg_*  register writes (heap end, even alignment, free id, invalid id);
//          issue them only while no request is in flight. cfg_ready is high.
// Timing: a request is taken only when the sequencer is idle. Query, actions
//   5 to 7 and a free of an address below the header go from the accepting
//   state straight to the result state; alloc and free pass through their own
//   state first. The next request is taken once the result has been handed on
//   and the sequencer is idle. Shift and compact walk the header chain below
//   the top through the single header RAM read port, read then evaluate per chunk.
// Reset: top of heap goes to zero, registers to their defaults; header RAM
//   contents stay; the user must read them only after writing, as the block does not check.
// Stall: a finished result sits in the output register; the next request may
//   be taken meanwhile, but its result waits until out_tready frees the slot.
module bump_heap_chunk_manager_core #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // size[12:0], chunk_id[28:13], id_range[44:29], address[56:45]
  input  logic [7:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[0], payload_offset[12:1], free_bytes[25:13],
                                  // reclaimed_bytes[38:26]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bhcm_pkg::IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(HEAP_BYTES);

  bhcm_pkg::cfg_t    cfg_r, cfg_nxt;
  bhcm_pkg::item_t   item;
  bhcm_pkg::result_t res;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_r, out_valid_nxt;
  logic [39:0]       out_data_r, out_data_nxt;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [bhcm_pkg::HDR_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [bhcm_pkg::HDR_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        bhcm_pkg::REG_HEAP_BYTES: cfg_nxt.heap_bytes = cfg_data[bhcm_pkg::SIZE_W-1:0];
        bhcm_pkg::REG_ALIGN_EVEN: cfg_nxt.align_even = cfg_data[0];
        bhcm_pkg::REG_FREE_ID:    cfg_nxt.free_id    = cfg_data;
        bhcm_pkg::REG_INVALID_ID: cfg_nxt.invalid_id = cfg_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heap_bytes <= 13'd4096;
      cfg_r.align_even <= 1'b0;
      cfg_r.free_id    <= 16'd0;
      cfg_r.invalid_id <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign item.action   = in_tuser[2:0];
  assign item.size     = in_tdata[12:0];
  assign item.chunk_id = in_tdata[28:13];
  assign item.id_range = in_tdata[44:29];
  assign item.address  = in_tdata[56:45];

  bhcm_ram #(
    .WIDTH (bhcm_pkg::HDR_W),
    .DEPTH (HEAP_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bhcm_seq #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output register, refilled in the cycle its beat is taken
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, res.reclaimed_bytes, res.free_bytes, res.payload_offset,
                       res.status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/bhcm_checker.sv
// ----------------------------------------------------------------------------
// bhcm_checker
// Port-level checks of the chunk manager, bound to the top level.
// ----------------------------------------------------------------------------
module bhcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat shown right after reset");

  // one request at a time: ready drops after an accepted beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // failed alloc reports a zero payload offset
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[12:1] == 12'd0)
    else $error("failed alloc with nonzero offset");

  // reclaimed bytes only come with a successful action
  a_reclaim_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[38:26] != 13'd0) |-> !out_tdata[0])
    else $error("reclaimed bytes with failure status");

endmodule

bind bump_heap_chunk_manager_core bhcm_checker u_bhcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### test/bump_heap_chunk_manager_core_test.sv
// ----------------------------------------------------------------------------
// bump_heap_chunk_manager_core_test
// Self-checking bench for the bump heap chunk manager. A short table of
// directed requests is followed by random alloc/free/shift/compact/query
// traffic under several register settings and idle patterns. Every result beat is
// compared with its table row or else a behavioral heap of chunk headers and top.
// ----------------------------------------------------------------------------
module bump_heap_chunk_manager_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIZE_W = bhcm_pkg::SIZE_W;
  localparam int ID_W   = bhcm_pkg::ID_W;
  localparam int ADDR_W = bhcm_pkg::ADDR_W;
  localparam int ACT_W  = bhcm_pkg::ACT_W;
  localparam int IDX_W  = bhcm_pkg::IDX_W;

  localparam int unsigned HEAP_BYTES   = 4096;
  localparam int unsigned HDR_BYTES    = 4;
  localparam int          SEG_ITEMS    = 272;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          STALL_LIMIT  = 20000;
  localparam int          TAIL_CYCLES  = 64;

  // action codes the block treats as a plain query
  localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata   = '0;  // size[12:0], chunk_id[28:13], id_range[44:29],
                                       // address[56:45]
  logic [7:0]        in_tuser   = '0;  // action[2:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [39:0]       out_tdata;        // status[0], payload_offset[12:1], free_bytes[25:13],
                                       // reclaimed_bytes[38:26]
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index  = bhcm_pkg::REG_HEAP_BYTES;
  logic [15:0]       cfg_data   = '0;

  bump_heap_chunk_manager_core #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HDR_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // behavioral heap
  bhcm_pkg::hdr_t    hdr_mem [0:HEAP_BYTES-1];
  bit                hdr_written [0:HEAP_BYTES-1];
  int unsigned       written_locs [$];
  int unsigned       heap_top = 0;
  logic [SIZE_W-1:0] cfg_heap = 13'd4096;
  logic              cfg_align = 1'b0;
  logic [ID_W-1:0]   cfg_free_id = 16'd0;
  logic [ID_W-1:0]   cfg_invalid_id = 16'd1;

  bhcm_pkg::result_t pending_results [$];
  int                fail_cnt = 0;
  int                snd_idle_pct = 34;
  int                rcv_idle_pct = 72;
  bit                hold_req = 1'b0;
  int                stall_cnt = 0;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   cid;
    logic [ID_W-1:0]   rng;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    logic              st;
    logic [ADDR_W-1:0] po;
    logic [SIZE_W-1:0] fb;
    logic [SIZE_W-1:0] rb;
  } dir_row_t;

  // defaults: heap 4096, no alignment, free id 0, invalid id 1
  dir_row_t dir_tab [$] = '{
    '{bhcm_pkg::ACT_QUERY,   0,       0,       0,       0,  1, 0, 0,  4096, 0},
    '{bhcm_pkg::ACT_ALLOC,   0,       5,       0,       0,  1, 0, 4,  4092, 0},
    '{bhcm_pkg::ACT_ALLOC,   7,       6,       0,       0,  1, 0, 8,  4081, 0},
    '{bhcm_pkg::ACT_ALLOC,   4096,    7,       0,       0,  1, 1, 0,  4081, 0},
    '{bhcm_pkg::ACT_ALLOC,   9,       16,      0,       0,  1, 0, 19, 4068, 0},
    '{bhcm_pkg::ACT_ALLOC,   3,       'hFFFF,  0,       0,  1, 0, 32, 4061, 0},
    '{bhcm_pkg::ACT_FREE,    0,       0,       0,       2,  1, 0, 0,  4061, 0},
    '{bhcm_pkg::ACT_FREE,    0,       0,       0,       8,  1, 0, 0,  4061, 0},
    '{ACT_RSVD5,             0,       0,       0,       0,  1, 0, 0,  4061, 0},
    '{ACT_RSVD6,             'h1FFF,  'hFFFF,  'hFFFF,  'hFFF, 1, 0, 0, 4061, 0},
    '{ACT_RSVD7,             0,       0,       0,       0,  1, 0, 0,  4061, 0},
    '{bhcm_pkg::ACT_SHIFT,   0,       16,      0,       0,  0, 0, 0,  0,    0},
    '{bhcm_pkg::ACT_SHIFT,   0,       5,       1,       0,  0, 0, 0,  0,    0},
    '{bhcm_pkg::ACT_COMPACT, 0,       0,       0,       0,  0, 0, 0,  0,    0},
    '{bhcm_pkg::ACT_QUERY,   0,       0,       0,       0,  0, 0, 0,  0,    0},
    '{bhcm_pkg::ACT_SHIFT,   0,       'hFFFF,  'hFFFF,  0,  0, 0, 0,  0,    0},
    '{bhcm_pkg::ACT_FREE,    0,       0,       0,       21, 0, 0, 0,  0,    0},
    '{bhcm_pkg::ACT_ALLOC,   4071,    'h1234,  0,       0,  0, 0, 0,  0,    0},
    '{bhcm_pkg::ACT_ALLOC,   0,       'hABCD,  0,       0,  0, 0, 0,  0,    0},
    '{bhcm_pkg::ACT_ALLOC,   0,       9,       0,       0,  1, 1, 0,  0,    0},
    '{bhcm_pkg::ACT_FREE,    0,       0,       0,       21, 0, 0, 0,  0,    0},
    '{bhcm_pkg::ACT_COMPACT, 0,       0,       0,       0,  0, 0, 0,  0,    0},
    '{bhcm_pkg::ACT_SHIFT,   0,       0,       'hFFFF,  0,  0, 0, 0,  0,    0},
    '{bhcm_pkg::ACT_COMPACT, 0,       0,       0,       0,  0, 0, 0,  0,    0}
  };

  function automatic int unsigned space_left();
    int unsigned e;
    e = (cfg_heap > HEAP_BYTES) ? HEAP_BYTES : cfg_heap;
    return (heap_top >= e) ? 0 : e - heap_top;
  endfunction

  // size of the chunk at loc when the walk may step over it, else 0
  function automatic int unsigned chain_step(int unsigned loc);
    int unsigned s;
    if (loc >= HEAP_BYTES || loc >= heap_top) return 0;
    s = hdr_mem[loc].size;
    if (s == 0 || loc + s > heap_top) return 0;
    return s;
  endfunction

  function automatic void store_hdr(int unsigned loc, bhcm_pkg::hdr_t h);
    hdr_mem[loc] = h;
    if (!hdr_written[loc]) begin
      hdr_written[loc] = 1'b1;
      written_locs.push_back(loc);
    end
  endfunction

  // collects the walkable header chain; returns 1 if the walk would read a
  // header that was never written
  function automatic bit scan_chain(output int unsigned locs [$]);
    int unsigned loc, s;
    locs = {};
    loc = 0;
    while (loc < HEAP_BYTES && loc < heap_top) begin
      if (!hdr_written[loc]) return 1'b1;
      s = chain_step(loc);
      if (s == 0) return 1'b0;
      locs.push_back(loc);
      loc += s;
    end
    return 1'b0;
  endfunction

  function automatic bhcm_pkg::result_t heap_apply(bhcm_pkg::item_t it);
    bhcm_pkg::result_t r;
    int unsigned       total, hloc, loc, s, lim, nid, moved;
    bhcm_pkg::hdr_t    h;
    r = '0;
    moved = 0;
    case (it.action)
      bhcm_pkg::ACT_ALLOC: begin
        total = it.size;
        if (cfg_align && total[0]) total++;
        total += HDR_BYTES;
        if (space_left() < total) begin
          r.status = 1'b1;
        end else begin
          h.id = it.chunk_id;
          h.size = total[SIZE_W-1:0];
          store_hdr(heap_top, h);
          r.payload_offset = ADDR_W'(heap_top + HDR_BYTES);
          heap_top += total;
        end
      end
      bhcm_pkg::ACT_FREE: begin
        if (it.address >= HDR_BYTES) begin
          hloc = it.address - HDR_BYTES;
          h = hdr_mem[hloc];
          if (hloc + h.size == heap_top) begin
            heap_top = hloc;
          end else begin
            h.id = cfg_free_id;
            store_hdr(hloc, h);
          end
        end
      end
      bhcm_pkg::ACT_SHIFT: begin
        // interval end is not wrapped to 16 bits
        lim = 32'(it.chunk_id) + 32'(it.id_range);
        loc = 0;
        s = chain_step(loc);
        while (s != 0) begin
          h = hdr_mem[loc];
          nid = h.id;
          if (nid >= it.chunk_id && nid < lim) nid = cfg_invalid_id;
          else if (nid >= lim) nid = nid - it.id_range;
          h.id = nid[ID_W-1:0];
          store_hdr(loc, h);
          loc += s;
          s = chain_step(loc);
        end
      end
      bhcm_pkg::ACT_COMPACT: begin
        loc = 0;
        s = chain_step(loc);
        while (s != 0) begin
          h = hdr_mem[loc];
          if (h.id == cfg_free_id) moved += s;
          else if (moved != 0) store_hdr(loc - moved, h);
          loc += s;
          s = chain_step(loc);
        end
        heap_top -= moved;
      end
      default: ;
    endcase
    r.free_bytes = SIZE_W'(space_left());
    r.reclaimed_bytes = SIZE_W'(moved);
    return r;
  endfunction

  function automatic bhcm_pkg::item_t next_op();
    bhcm_pkg::item_t it;
    int unsigned     locs [$];
    int unsigned     tops [$];
    int unsigned     roll, sub, a;
    bit              have;
    it.action = bhcm_pkg::ACT_QUERY;
    it.size = SIZE_W'($urandom_range(0, 4096));
    it.chunk_id = ID_W'($urandom);
    it.id_range = ID_W'($urandom);
    it.address = ADDR_W'($urandom_range(0, HEAP_BYTES - 1));
    roll = $urandom_range(0, 99);
    sub = $urandom_range(0, 99);
    have = 1'b0;
    a = 0;
    if (roll < 40) begin
      it.action = bhcm_pkg::ACT_ALLOC;
      if (sub < 80) it.size = SIZE_W'($urandom_range(0, 96));
      else if (sub < 95) it.size = SIZE_W'($urandom_range(0, 600));
      if ($urandom_range(0, 99) < 5) it.chunk_id = cfg_free_id;
      else if ($urandom_range(0, 1) == 0) it.chunk_id = ID_W'($urandom_range(0, 31));
    end else if (roll < 65) begin
      it.action = bhcm_pkg::ACT_FREE;
      void'(scan_chain(locs));
      if (sub < 60 && locs.size() != 0) begin
        a = (sub < 15) ? locs[locs.size()-1] : locs[$urandom_range(0, locs.size()-1)];
        have = 1'b1;
      end else if (sub < 75) begin
        // any written header that ends at the top, live or stale
        foreach (written_locs[i])
          if (written_locs[i] + hdr_mem[written_locs[i]].size == heap_top)
            tops.push_back(written_locs[i]);
        if (tops.size() != 0) begin
          a = tops[$urandom_range(0, tops.size()-1)];
          have = 1'b1;
        end
      end else if (sub < 88 && written_locs.size() != 0) begin
        a = written_locs[$urandom_range(0, written_locs.size()-1)];
        have = 1'b1;
      end
      if (have && a + HDR_BYTES < HEAP_BYTES) it.address = ADDR_W'(a + HDR_BYTES);
      else it.address = ADDR_W'($urandom_range(0, HDR_BYTES - 1));
    end else if (roll < 77) begin
      it.action = bhcm_pkg::ACT_SHIFT;
      if (sub < 70) begin
        it.chunk_id = ID_W'($urandom_range(0, 40));
        it.id_range = ID_W'($urandom_range(0, 8));
      end
    end else if (roll < 87) begin
      it.action = bhcm_pkg::ACT_COMPACT;
    end else if (roll >= 95) begin
      it.action = ACT_W'($urandom_range(ACT_RSVD5, ACT_RSVD7));
    end
    // a walk over a never-written header is not allowed
    if ((it.action == bhcm_pkg::ACT_SHIFT || it.action == bhcm_pkg::ACT_COMPACT) &&
        scan_chain(locs))
      it.action = bhcm_pkg::ACT_QUERY;
    return it;
  endfunction

  task automatic send_item(input bhcm_pkg::item_t it, input bit typed,
                           input bhcm_pkg::result_t typed_res);
    bhcm_pkg::result_t want;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {5'b0, it.action};
    in_tdata  <= {7'b0, it.address, it.id_range, it.chunk_id, it.size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = heap_apply(it);
    pending_results.push_back(typed ? typed_res : want);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bhcm_pkg::REG_HEAP_BYTES: cfg_heap = val[SIZE_W-1:0];
      bhcm_pkg::REG_ALIGN_EVEN: cfg_align = val[0];
      bhcm_pkg::REG_FREE_ID:    cfg_free_id = val;
      bhcm_pkg::REG_INVALID_ID: cfg_invalid_id = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned heap, input bit align,
                            input logic [15:0] fid, input logic [15:0] iid);
    write_reg(bhcm_pkg::REG_HEAP_BYTES, 16'(heap));
    write_reg(bhcm_pkg::REG_ALIGN_EVEN, {15'b0, align});
    write_reg(bhcm_pkg::REG_FREE_ID, fid);
    write_reg(bhcm_pkg::REG_INVALID_ID, iid);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side: random back-pressure plus an occasional long hold
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    bhcm_pkg::result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status          = out_tdata[0];
      got.payload_offset  = out_tdata[12:1];
      got.free_bytes      = out_tdata[25:13];
      got.reclaimed_bytes = out_tdata[38:26];
      if (pending_results.size() == 0) begin
        $error("result beat with no request pending: %h", out_tdata);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_cnt++;
        end
        if (got.payload_offset !== want.payload_offset) begin
          $error("payload_offset: expected %0d, got %0d",
                 want.payload_offset, got.payload_offset);
          fail_cnt++;
        end
        if (got.free_bytes !== want.free_bytes) begin
          $error("free_bytes: expected %0d, got %0d", want.free_bytes, got.free_bytes);
          fail_cnt++;
        end
        if (got.reclaimed_bytes !== want.reclaimed_bytes) begin
          $error("reclaimed_bytes: expected %0d, got %0d",
                 want.reclaimed_bytes, got.reclaimed_bytes);
          fail_cnt++;
        end
      end
    end
  end

  // cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    bhcm_pkg::item_t   it;
    bhcm_pkg::result_t want;
    int unsigned       heap;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_config(4096, 1'b0, 16'd0, 16'd1);

    foreach (dir_tab[i]) begin
      it.action   = dir_tab[i].act;
      it.size     = dir_tab[i].size;
      it.chunk_id = dir_tab[i].cid;
      it.id_range = dir_tab[i].rng;
      it.address  = dir_tab[i].addr;
      want.status          = dir_tab[i].st;
      want.payload_offset  = dir_tab[i].po;
      want.free_bytes      = dir_tab[i].fb;
      want.reclaimed_bytes = dir_tab[i].rb;
      send_item(it, dir_tab[i].typed, want);
    end
    in_tvalid <= 1'b0;
    wait_drain();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: set_config(4096, 1'b1, 16'hFFFF, 16'h0000);
        1: begin
          // end of heap below the current top
          heap = (heap_top > 0) ? $urandom_range(0, heap_top - 1) : 0;
          set_config(heap, 1'b0, 16'($urandom_range(0, 3)), 16'($urandom));
        end
        2: set_config(0, 1'b1, 16'($urandom_range(0, 3)), 16'($urandom));
        3: set_config(4096, 1'b1, 16'd0, 16'hFFFF);
        4: set_config($urandom_range(64, 4096), 1'($urandom), 16'd1, 16'd1);
        default: set_config(4096, 1'b0, 16'd0, 16'd1);
      endcase
      if (seg < 2) begin
        snd_idle_pct = 34;
        rcv_idle_pct = 72;
      end else if (seg < 4) begin
        snd_idle_pct = 72;
        rcv_idle_pct = 34;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if (seg == 4) hold_req = 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++) send_item(next_op(), 1'b0, '0);
      in_tvalid <= 1'b0;
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
